FILE: rtl/wbps_pkg.sv
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants and types for the wildcard byte pattern scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

	localparam int REG_PATTERN_BYTES    = 16;
	localparam int PATTERN_MAX_DEF      = 16;
	localparam int POSITION_WIDTH_DEF   = 32;
	localparam int LEN_W                = 5;
	localparam int CARE_W               = 16;
	localparam int CFG_DATA_W           = 64;
	localparam int CFG_ADDR_W           = 6;
	localparam int ADDR_W               = 64;

	localparam logic [2:0] REG_REGION_BASE    = 3'd0;
	localparam logic [2:0] REG_PATTERN_LOW    = 3'd1;
	localparam logic [2:0] REG_PATTERN_HIGH   = 3'd2;
	localparam logic [2:0] REG_CARE_MASK      = 3'd3;
	localparam logic [2:0] REG_PATTERN_LENGTH = 3'd4;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

FILE: rtl/wbps_cell.sv
// ----------------------------------------------------------------------------
// wbps_cell
// One window cell: holds a byte, its read flag and a fill mark, shifts them on
// to the next cell, and checks the incoming byte against its aligned pattern.
// ----------------------------------------------------------------------------
module wbps_cell
	import wbps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [7:0] din_byte,
	input  logic       din_valid,
	input  logic       din_filled,
	input  logic [7:0] pat_byte,
	input  logic       care,
	output logic [7:0] dout_byte,
	output logic       dout_valid,
	output logic       dout_filled,
	output logic       ok
);

	logic [7:0] byte_q;
	logic       valid_q;
	logic       filled_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q  <= din_byte;
			valid_q <= din_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
		end else if (ctrl.clear) begin
			filled_q <= 1'b0;
		end else if (ctrl.shift) begin
			filled_q <= din_filled;
		end
	end

	// care byte must have been read and equal; wildcards pass anything
	assign ok          = !care || (din_valid && (din_byte == pat_byte));
	assign dout_byte   = byte_q;
	assign dout_valid  = valid_q;
	assign dout_filled = filled_q;

endmodule

FILE: rtl/wildcard_byte_pattern_scan.sv
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scan
// Streams region bytes through a row of window cells and reports the address
// of the first wildcard pattern match, or not found at the region's end.
// ----------------------------------------------------------------------------
// channel   | dir | tdata              | tuser        | tlast
// s_        | in  | data_byte[7:0]     | read_ok      | last
// m_        | out | match_address[63:0]| found        | -
// apb       | in  | 64-bit registers at byte address 8*i
//
// One byte per cycle while s_tready is high; the window compare is done in the accept cycle.
// A result passes the compare stage, then the address add stage, before it reaches m_.
// s_tready drops only while both result stages are full and m_tready is low.
// Reset clears configuration, window fill marks, position and result stages.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan
	import wbps_pkg::*;
#(
	parameter int PATTERN_MAX    = PATTERN_MAX_DEF,
	parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,   // data_byte
	input  logic                  s_tuser,   // read_ok
	input  logic                  s_tlast,   // last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ADDR_W-1:0]     m_tdata,   // match_address
	output logic                  m_tuser,   // found
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int EFF   = (PATTERN_MAX < REG_PATTERN_BYTES) ? PATTERN_MAX : REG_PATTERN_BYTES;
	localparam int IDX_W = (EFF > 1) ? $clog2(EFF) : 1;

	// configuration
	logic [ADDR_W-1:0] region_base_q;
	logic [63:0]       pattern_low_q;
	logic [63:0]       pattern_high_q;
	logic [CARE_W-1:0] care_mask_q;
	logic [LEN_W-1:0]  pattern_length_q;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q    <= '0;
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_REGION_BASE:    region_base_q    <= pwdata;
				REG_PATTERN_LOW:    pattern_low_q    <= pwdata;
				REG_PATTERN_HIGH:   pattern_high_q   <= pwdata;
				REG_CARE_MASK:      care_mask_q      <= pwdata[CARE_W-1:0];
				REG_PATTERN_LENGTH: pattern_length_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_REGION_BASE:    prdata = region_base_q;
			REG_PATTERN_LOW:    prdata = pattern_low_q;
			REG_PATTERN_HIGH:   prdata = pattern_high_q;
			REG_CARE_MASK:      prdata = {{(CFG_DATA_W-CARE_W){1'b0}}, care_mask_q};
			REG_PATTERN_LENGTH: prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, pattern_length_q};
			default:            prdata = '0;
		endcase
	end

	// effective length and pattern
	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] len_m1;
	logic [127:0]     pat_all;

	assign len_eff = (pattern_length_q > LEN_W'(EFF)) ? LEN_W'(EFF) : pattern_length_q;
	assign len_m1  = len_eff - LEN_W'(1);
	assign pat_all = {pattern_high_q, pattern_low_q};

	// control and window chain
	logic             s_accept;
	logic             match_done_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	cell_ctrl_t       cell_ctrl;

	logic [7:0]       c_byte   [EFF];
	logic             c_valid  [EFF];
	logic             c_filled [EFF];
	logic [EFF-1:0]   in_filled;
	logic [EFF-1:0]   ok;

	assign s_accept        = s_tvalid && s_tready;
	assign cell_ctrl.shift = s_accept && !match_done_q;
	assign cell_ctrl.clear = s_accept && s_tlast;

	for (genvar k = 0; k < EFF; k++) begin : g_cell
		logic [LEN_W-1:0] j;
		logic [7:0]       pat_k;
		logic             care_k;
		logic [7:0]       din_byte;
		logic             din_valid;
		logic             din_filled;

		assign j      = len_m1 - LEN_W'(k);
		assign pat_k  = pat_all[{j[3:0], 3'b000} +: 8];
		assign care_k = (LEN_W'(k) < len_eff) && care_mask_q[j[3:0]];

		if (k == 0) begin : g_head
			assign din_byte   = s_tdata;
			assign din_valid  = s_tuser;
			assign din_filled = 1'b1;
		end else begin : g_body
			assign din_byte   = c_byte[k-1];
			assign din_valid  = c_valid[k-1];
			assign din_filled = c_filled[k-1];
		end

		assign in_filled[k] = din_filled;

		wbps_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (cell_ctrl),
			.din_byte    (din_byte),
			.din_valid   (din_valid),
			.din_filled  (din_filled),
			.pat_byte    (pat_k),
			.care        (care_k),
			.dout_byte   (c_byte[k]),
			.dout_valid  (c_valid[k]),
			.dout_filled (c_filled[k]),
			.ok          (ok[k])
		);
	end

	logic                      hit;
	logic                      result;
	logic [POSITION_WIDTH-1:0] offset;

	assign hit    = (len_eff == '0) || (in_filled[len_m1[IDX_W-1:0]] && (&ok));
	assign result = s_accept && !match_done_q && (hit || s_tlast);
	assign offset = (len_eff == '0) ? pos_q : pos_q - POSITION_WIDTH'(len_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_done_q <= 1'b0;
			pos_q        <= '0;
		end else if (s_accept) begin
			if (s_tlast) begin
				match_done_q <= 1'b0;
				pos_q        <= '0;
			end else if (!match_done_q) begin
				match_done_q <= hit;
				pos_q        <= pos_q + POSITION_WIDTH'(1);
			end
		end
	end

	// result stages
	logic                      valid_s1;
	logic                      found_s1;
	logic [POSITION_WIDTH-1:0] offset_s1;
	logic                      m_tvalid_q;
	logic                      found_q;
	logic [ADDR_W-1:0]         addr_q;
	logic                      out_free;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= result;
			end
			if (out_free) begin
				m_tvalid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result) begin
			found_s1  <= hit;
			offset_s1 <= offset;
		end
		if (out_free && valid_s1) begin
			found_q <= found_s1;
			addr_q  <= found_s1 ? region_base_q + ADDR_W'(offset_s1) : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = found_q;
	assign m_tdata  = addr_q;

endmodule

FILE: rtl/wbps_checker.sv
// ----------------------------------------------------------------------------
// wbps_port_checker
// Port-level checks on the scanner's result channel and input backpressure.
// ----------------------------------------------------------------------------
module wbps_port_checker
	import wbps_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [ADDR_W-1:0] m_tdata,
	input logic              m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("not-found item with nonzero address");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without a stalled result");

endmodule

bind wildcard_byte_pattern_scan wbps_port_checker u_wbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
